[hdl/b64d_pkg.sv]
// Types, constants and character decode function for the base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_final;
  } char_req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       failed;
    logic       msg_end;
  } res_req_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Up to three results produced by one character.
  typedef struct packed {
    logic [1:0]           cnt;
    res_req_t [2:0]       res;
  } bundle_t;

  localparam res_req_t RES_ERROR   = '{data_byte: 8'h00, byte_valid: 1'b0,
                                       failed: 1'b1, msg_end: 1'b1};
  localparam res_req_t RES_BARE_END = '{data_byte: 8'h00, byte_valid: 1'b0,
                                        failed: 1'b0, msg_end: 1'b1};

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.ok  = 1'b1;
    s.val = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS) begin
      s.val = 6'd62;
    end else if (c == CHAR_SLASH) begin
      s.val = 6'd63;
    end else if (c == CHAR_PAD) begin
      s.val = 6'd0;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

[hdl/base64_stream_decoder.sv]
// Top level: streaming base64 decoder with input register and result serializer.
// A result passes through the input register and then the result register before it is offered.
// Throughput: one character per cycle while char_stall is low; a character completing a group
//   loads up to three bytes into the result register, shown one per cycle while res_stall is low,
//   and the next character that yields results waits until that register drains.
// Reset (rst, synchronous): clears the group, the discard flag and both valid stages.
module base64_stream_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  b64d_pkg::char_req_t  char_req,
  output logic                 res_valid,
  input  logic                 res_stall,
  output b64d_pkg::res_req_t   res_req
);

  // input register
  logic                item_vld;
  b64d_pkg::char_req_t item;

  // decoder state
  logic [17:0] group_accum;
  logic [17:0] group_accum_next;
  logic [1:0]  char_count;
  logic [1:0]  char_count_next;
  logic        discarding;
  logic        discarding_next;

  // result serializer
  b64d_pkg::res_req_t [2:0] ser_res;
  logic [1:0]               ser_cnt;
  logic [1:0]               ser_idx;

  b64d_pkg::bundle_t bundle;
  b64d_pkg::sextet_t sx;
  logic [23:0]       full;
  logic [7:0]        b0, b1, b2;
  logic              res_accept;
  logic              ser_free;
  logic              item_move;
  logic              load;

  assign res_accept = res_valid && !res_stall;
  assign ser_free   = (ser_cnt == 2'd0) || (ser_cnt == 2'd1 && res_accept);
  assign item_move  = item_vld && ((bundle.cnt == 2'd0) || ser_free);
  assign load       = item_move && (bundle.cnt != 2'd0);
  assign char_stall = item_vld && !item_move;

  assign sx   = b64d_pkg::sextet_of(item.char_in);
  assign full = {group_accum, sx.val};
  assign b0   = full[23:16];
  assign b1   = full[15:8];
  assign b2   = full[7:0];

  always_comb begin
    bundle           = '0;
    group_accum_next = group_accum;
    char_count_next  = char_count;
    discarding_next  = discarding;
    if (discarding) begin
      if (item.is_final) begin
        discarding_next  = 1'b0;
        group_accum_next = '0;
        char_count_next  = '0;
      end
    end else if (item.char_in == b64d_pkg::CHAR_NEWLINE) begin
      if (item.is_final) begin
        group_accum_next = '0;
        char_count_next  = '0;
        bundle.cnt       = 2'd1;
        bundle.res[0]    = b64d_pkg::RES_ERROR;
      end
    end else if (!sx.ok) begin
      group_accum_next = '0;
      char_count_next  = '0;
      discarding_next  = !item.is_final;
      bundle.cnt       = 2'd1;
      bundle.res[0]    = b64d_pkg::RES_ERROR;
    end else if (char_count != 2'd3) begin
      group_accum_next = {group_accum[11:0], sx.val};
      char_count_next  = char_count + 2'd1;
      if (item.is_final) begin
        group_accum_next = '0;
        char_count_next  = '0;
        bundle.cnt       = 2'd1;
        bundle.res[0]    = b64d_pkg::RES_ERROR;
      end
    end else begin
      group_accum_next = '0;
      char_count_next  = '0;
      bundle.res[0]    = '{data_byte: b0, byte_valid: 1'b1, failed: 1'b0, msg_end: 1'b0};
      bundle.res[1]    = '{data_byte: b1, byte_valid: 1'b1, failed: 1'b0, msg_end: 1'b0};
      bundle.res[2]    = '{data_byte: b2, byte_valid: 1'b1, failed: 1'b0, msg_end: 1'b0};
      if (!item.is_final) begin
        bundle.cnt = 2'd3;
      end else if (b0 == 8'd0) begin
        bundle.cnt    = 2'd1;
        bundle.res[0] = b64d_pkg::RES_BARE_END;
      end else if (b1 == 8'd0) begin
        bundle.cnt            = 2'd1;
        bundle.res[0].msg_end = 1'b1;
      end else if (b2 == 8'd0) begin
        bundle.cnt            = 2'd2;
        bundle.res[1].msg_end = 1'b1;
      end else begin
        bundle.cnt            = 2'd3;
        bundle.res[2].msg_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (!char_stall) begin
      item_vld <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      item <= char_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_accum <= '0;
      char_count  <= '0;
      discarding  <= 1'b0;
    end else if (item_move) begin
      group_accum <= group_accum_next;
      char_count  <= char_count_next;
      discarding  <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_cnt <= '0;
      ser_idx <= '0;
    end else if (load) begin
      ser_cnt <= bundle.cnt;
      ser_idx <= '0;
    end else if (res_accept) begin
      ser_cnt <= ser_cnt - 2'd1;
      ser_idx <= ser_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_res <= bundle.res;
    end
  end

  assign res_valid = (ser_cnt != 2'd0);
  assign res_req   = ser_res[ser_idx];

  a_ser_range: assert property (@(posedge clk) disable iff (rst)
    (ser_cnt != 2'd0) |-> (({1'b0, ser_idx} + {1'b0, ser_cnt}) <= 3'd3))
    else $error("serializer index past loaded results");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> ((ser_cnt == 2'd0) || (ser_cnt == 2'd1 && res_accept)))
    else $error("pending results overwritten");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (item_move && item.is_final) |=> (char_count == 2'd0 && !discarding))
    else $error("group not cleared after final character");

  a_discard_empty: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (char_count == 2'd0 && group_accum == 18'd0))
    else $error("group not empty while discarding");

endmodule
